// File: hdl/mocl_pkg.sv
`default_nettype none

package mocl_pkg;

    // Field widths.
    localparam int SAMPLE_W   = 16;
    localparam int NUM_AXES   = 3;
    localparam int NIB_W      = 4;
    localparam int FLAGS_W    = NUM_AXES * NIB_W;
    localparam int STATE_W    = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int S_TDATA_W  = 2 * NUM_AXES * SAMPLE_W;
    localparam int RESULT_W   = FLAGS_W + STATE_W + 1 + STATE_W;
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // Default thresholds: one g and ninety dps, each less a margin.
    localparam int ONE_G             = 8192;
    localparam int ONE_G_MARGIN      = 2000;
    localparam int NINETY_DPS        = 11796;
    localparam int NINETY_DPS_MARGIN = 1500;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t ACCEL_HIGH_RESET = sample_t'(ONE_G - ONE_G_MARGIN);
    localparam sample_t ACCEL_LOW_RESET  = sample_t'(ONE_G_MARGIN - ONE_G);
    localparam sample_t GYRO_HIGH_RESET  = sample_t'(NINETY_DPS - NINETY_DPS_MARGIN);
    localparam sample_t GYRO_LOW_RESET   = sample_t'(NINETY_DPS_MARGIN - NINETY_DPS);

    // Motion state code for "no match" / "none held yet".
    localparam logic [STATE_W-1:0] STATE_NONE = 4'd12;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ACCEL_HIGH = 2'd0,
        REG_ACCEL_LOW  = 2'd1,
        REG_GYRO_HIGH  = 2'd2,
        REG_GYRO_LOW   = 2'd3
    } cfg_reg_t;

    // Axis nibble patterns that name a direction.
    localparam logic [NIB_W-1:0] NIB_UP      = 4'h1;
    localparam logic [NIB_W-1:0] NIB_DOWN    = 4'h2;
    localparam logic [NIB_W-1:0] NIB_RIGHT_A = 4'h5;
    localparam logic [NIB_W-1:0] NIB_RIGHT_B = 4'h6;
    localparam logic [NIB_W-1:0] NIB_LEFT_A  = 4'h9;
    localparam logic [NIB_W-1:0] NIB_LEFT_B  = 4'hA;

    // Direction within an axis; the state code is axis * 4 + direction.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // One inertial sample; accel_x sits in the lowest bits.
    typedef struct packed {
        sample_t rate_z;
        sample_t rate_y;
        sample_t rate_x;
        sample_t accel_z;
        sample_t accel_y;
        sample_t accel_x;
    } sample_set_t;

    typedef struct packed {
        sample_t accel_high;
        sample_t accel_low;
        sample_t gyro_high;
        sample_t gyro_low;
    } thresholds_t;

    // One result; motion_flags sits in the lowest bits.
    typedef struct packed {
        logic [STATE_W-1:0] held_state;
        logic               state_changed;
        logic [STATE_W-1:0] decoded_state;
        logic [FLAGS_W-1:0] motion_flags;
    } result_t;

    // Next value of one flag pair, {neg, pos}. Tests are made in a fixed
    // order so that crossed thresholds behave the same as the spec.
    function automatic logic [1:0] pair_next(input sample_t v, input sample_t hi,
                                             input sample_t lo, input logic [1:0] cur);
        logic [1:0] nxt;
        nxt = cur;
        if (v > hi) begin
            nxt[0] = 1'b1;
        end else if (v < hi && v > lo) begin
            nxt = 2'b00;
        end else if (v < lo) begin
            nxt[1] = 1'b1;
        end
        return nxt;
    endfunction

    // Decode one axis nibble: bit 2 is the match flag, bits 1..0 the direction.
    function automatic logic [2:0] nib_decode(input logic [NIB_W-1:0] nib);
        logic [2:0] code;
        case (nib) inside
            NIB_UP:                   code = {1'b1, DIR_UP};
            NIB_DOWN:                 code = {1'b1, DIR_DOWN};
            NIB_RIGHT_A, NIB_RIGHT_B: code = {1'b1, DIR_RIGHT};
            NIB_LEFT_A, NIB_LEFT_B:   code = {1'b1, DIR_LEFT};
            default:                  code = 3'b000;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: hdl/motion_orientation_classifier_top.sv
// Path: a sample transferred into the input register passes through the flag
// update and table decode into the result register, which drives m_tdata.
// Throughput: one sample per cycle while m_tready is high; the flag update and
// table decode share a single combinational stage between the two registers.
// Reset: synchronous, active low; clears the flags and stage valid bits, sets
// the held state to none and restores the default thresholds.
`default_nettype none

module motion_orientation_classifier_top
    import mocl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Configuration write port.
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [SAMPLE_W-1:0]   cfg_wr_data,

    // Sample stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // Fields from bit 0: accel_x, accel_y, accel_z, rate_x, rate_y, rate_z.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,

    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: motion_flags, decoded_state, state_changed,
    // held_state, zero padding.
    output logic [M_TDATA_W-1:0]       m_tdata
);

    logic               in_valid_reg;
    sample_set_t        in_data_reg;
    logic               out_valid_reg;
    result_t            out_data_reg;
    logic [FLAGS_W-1:0] flag_reg;
    logic [STATE_W-1:0] held_state_reg;
    thresholds_t        thr_reg;

    logic               advance;
    logic               step;
    logic [FLAGS_W-1:0] flags_next;
    logic [STATE_W-1:0] held_next;
    result_t            result;

    // The result register frees up when empty or when its transfer completes.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;

    mocl_flag_update u_flag_update (
        .samples    (in_data_reg),
        .thr        (thr_reg),
        .flags_cur  (flag_reg),
        .flags_next (flags_next)
    );

    mocl_classify u_classify (
        .flags     (flags_next),
        .held_cur  (held_state_reg),
        .result    (result),
        .held_next (held_next)
    );

    // Threshold registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.accel_high <= ACCEL_HIGH_RESET;
            thr_reg.accel_low  <= ACCEL_LOW_RESET;
            thr_reg.gyro_high  <= GYRO_HIGH_RESET;
            thr_reg.gyro_low   <= GYRO_LOW_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_ACCEL_HIGH: thr_reg.accel_high <= cfg_wr_data;
                REG_ACCEL_LOW:  thr_reg.accel_low  <= cfg_wr_data;
                REG_GYRO_HIGH:  thr_reg.gyro_high  <= cfg_wr_data;
                REG_GYRO_LOW:   thr_reg.gyro_low   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Control state: stage valid bits, latched flags and held state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            flag_reg       <= '0;
            held_state_reg <= STATE_NONE;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (step) begin
                flag_reg       <= flags_next;
                held_state_reg <= held_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= sample_set_t'(s_tdata);
        end
        if (step) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, out_data_reg};

`ifndef SYNTHESIS
    // A reported change always carries the new state as the held state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.state_changed
        |-> out_data_reg.held_state == out_data_reg.decoded_state)
        else $error("changed result does not hold its decoded state");

    // A valid decode without a change means the state was already held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_data_reg.state_changed
        && out_data_reg.decoded_state != STATE_NONE
        |-> out_data_reg.held_state == out_data_reg.decoded_state)
        else $error("unchanged valid decode differs from held state");

    // Latched flags and held state move only when a sample passes through.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(flag_reg) && $stable(held_state_reg))
        else $error("state changed without a sample");

    // Reset leaves no held state and clears the latched flags.
    assert property (@(posedge aclk)
        !aresetn |=> held_state_reg == STATE_NONE && flag_reg == '0)
        else $error("reset did not clear the classifier state");
`endif

endmodule

`default_nettype wire

// File: hdl/mocl_flag_update.sv
`default_nettype none

module mocl_flag_update
    import mocl_pkg::*;
(
    input  wire sample_set_t         samples,
    input  wire thresholds_t         thr,
    input  wire logic [FLAGS_W-1:0]  flags_cur,
    output logic      [FLAGS_W-1:0]  flags_next
);

    // Each axis nibble: bits 1..0 from acceleration, bits 3..2 from rotation rate.
    always_comb begin
        flags_next[1:0]   = pair_next(samples.accel_x, thr.accel_high, thr.accel_low,
                                      flags_cur[1:0]);
        flags_next[5:4]   = pair_next(samples.accel_y, thr.accel_high, thr.accel_low,
                                      flags_cur[5:4]);
        flags_next[9:8]   = pair_next(samples.accel_z, thr.accel_high, thr.accel_low,
                                      flags_cur[9:8]);
        flags_next[3:2]   = pair_next(samples.rate_x, thr.gyro_high, thr.gyro_low,
                                      flags_cur[3:2]);
        flags_next[7:6]   = pair_next(samples.rate_y, thr.gyro_high, thr.gyro_low,
                                      flags_cur[7:6]);
        flags_next[11:10] = pair_next(samples.rate_z, thr.gyro_high, thr.gyro_low,
                                      flags_cur[11:10]);
    end

endmodule

`default_nettype wire

// File: hdl/mocl_classify.sv
`default_nettype none

module mocl_classify
    import mocl_pkg::*;
(
    input  wire logic [FLAGS_W-1:0] flags,
    input  wire logic [STATE_W-1:0] held_cur,
    output result_t                 result,
    output logic      [STATE_W-1:0] held_next
);

    logic [STATE_W-1:0] dec;
    logic               changed;

    // Only one axis nibble may be nonzero; a direction pattern there names the state, else none.
    always_comb begin
        logic [NIB_W-1:0]   nib;
        logic [FLAGS_W-1:0] others;
        logic [2:0]         code;
        dec = STATE_NONE;
        for (int a = 0; a < NUM_AXES; a++) begin
            nib    = flags[a*NIB_W +: NIB_W];
            others = flags & ~(FLAGS_W'(4'hF) << (a * NIB_W));
            code   = nib_decode(nib);
            if (nib != '0 && others == '0 && code[2]) begin
                dec = {2'(a), code[1:0]};
            end
        end
    end

    // A valid state that differs from the held one replaces it.
    assign changed   = (dec != STATE_NONE) && (dec != held_cur);
    assign held_next = changed ? dec : held_cur;

    assign result.motion_flags  = flags;
    assign result.decoded_state = dec;
    assign result.state_changed = changed;
    assign result.held_state    = held_next;

endmodule

`default_nettype wire
